// ===== rtl/xbc_pkg.sv =====
// XOR/Base64 codec package: register indexes, result types and alphabet functions.
// Used by every module of the codec; depends on nothing.
`default_nettype none
package xbc_pkg;

  localparam int KEY_BYTES = 8;
  localparam logic [3:0] KEY_LEN_MAX = 4'(KEY_BYTES);

  localparam logic MODE_ENC = 1'b0;
  localparam logic MODE_DEC = 1'b1;

  localparam int ADDR_W = 5;
  localparam logic [1:0] REG_MODE    = 2'd0;
  localparam logic [1:0] REG_XOR_KEY = 2'd1;
  localparam logic [1:0] REG_KEY_LEN = 2'd2;

  localparam logic [7:0] INVALID_VAL = 8'hFF;
  localparam logic [7:0] PAD_CHAR    = 8'h3D;  // '='
  localparam int MAX_RES = 4;

  typedef struct packed {
    logic [7:0] data;
    logic       empty;
    logic       last;
    logic       bad;
  } res_t;

  typedef struct packed {
    res_t [MAX_RES-1:0] item;
    logic [2:0]         cnt;
  } batch_t;

  function automatic logic [7:0] b64_char(input logic [5:0] six);
    logic [7:0] s;
    s = {2'b00, six};
    if (s < 8'd26)      return 8'h41 + s;           // 'A'..'Z'
    else if (s < 8'd52) return 8'h61 + s - 8'd26;   // 'a'..'z'
    else if (s < 8'd62) return 8'h30 + s - 8'd52;   // '0'..'9'
    else if (s == 8'd62) return 8'h2B;              // '+'
    else                return 8'h2F;               // '/'
  endfunction

  function automatic logic [7:0] b64_value(input logic [7:0] ch);
    if (ch inside {[8'h41:8'h5A]})      return ch - 8'h41;
    else if (ch inside {[8'h61:8'h7A]}) return ch - 8'h61 + 8'd26;
    else if (ch inside {[8'h30:8'h39]}) return ch - 8'h30 + 8'd52;
    else if (ch == 8'h2B)               return 8'd62;
    else if (ch == 8'h2F)               return 8'd63;
    else                                return INVALID_VAL;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/xbc_core.sv =====
// XOR/Base64 codec core: stream state and per-item result batch computation.
// Depends on xbc_pkg.
`default_nettype none
module xbc_core (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       clear,
  input  wire logic                       mode,
  input  wire logic [63:0]                xor_key,
  input  wire logic [3:0]                 key_len,
  input  wire logic                       fire,
  input  wire logic [7:0]                 item_byte,
  input  wire logic                       item_last,
  output xbc_pkg::batch_t                 batch
);
  import xbc_pkg::*;

  localparam logic [1:0] PH_0 = 2'd0;
  localparam logic [1:0] PH_1 = 2'd1;
  localparam logic [1:0] PH_2 = 2'd2;
  localparam logic [1:0] PH_3 = 2'd3;

  logic [1:0] phase_r, phase_nxt;
  logic [7:0] carry_r, carry_nxt;
  logic [2:0] kidx_r, kidx_nxt;
  logic       pad_r, pad_nxt;

  logic [3:0] len;
  logic [2:0] idx;
  logic [3:0] idx_inc;
  logic [2:0] idx_adv;
  logic [7:0] kb;
  logic [7:0] x;
  logic [7:0] v;
  logic [7:0] dec_b;
  logic       prev_bad;
  logic       cur_bad;
  logic [2:0] n;
  logic [1:0] lidx;
  batch_t     b;

  always_comb begin
    len = key_len;
    if (len == 4'd0) begin
      len = 4'd1;
    end else if (len > KEY_LEN_MAX) begin
      len = KEY_LEN_MAX;
    end
    idx     = ({1'b0, kidx_r} >= len) ? 3'd0 : kidx_r;
    kb      = xor_key[{idx, 3'b000} +: 8];
    idx_inc = {1'b0, idx} + 4'd1;
    idx_adv = (idx_inc >= len) ? 3'd0 : idx_inc[2:0];
    x       = item_byte ^ kb;
    v       = b64_value(item_byte);
    prev_bad = (carry_r == INVALID_VAL);
    cur_bad  = 1'b0;
    dec_b    = 8'd0;

    phase_nxt = phase_r;
    carry_nxt = carry_r;
    kidx_nxt  = kidx_r;
    pad_nxt   = pad_r;
    b         = '0;
    n         = 3'd0;

    if (mode == MODE_ENC) begin
      kidx_nxt = idx_adv;
      case (phase_r)
        PH_0: begin
          b.item[0].data = b64_char(x[7:2]);
          carry_nxt      = {2'b00, x[1:0], 4'b0000};
          phase_nxt      = PH_1;
          n              = 3'd1;
        end
        PH_1: begin
          b.item[0].data = b64_char(carry_r[5:0] | {2'b00, x[7:4]});
          carry_nxt      = {2'b00, x[3:0], 2'b00};
          phase_nxt      = PH_2;
          n              = 3'd1;
        end
        default: begin
          b.item[0].data = b64_char(carry_r[5:0] | {4'b0000, x[7:6]});
          b.item[1].data = b64_char(x[5:0]);
          carry_nxt      = 8'd0;
          phase_nxt      = PH_0;
          n              = 3'd2;
        end
      endcase
      // flush the partial group with padding
      if (item_last && phase_nxt == PH_1) begin
        b.item[1].data = b64_char(carry_nxt[5:0]);
        b.item[2].data = PAD_CHAR;
        b.item[3].data = PAD_CHAR;
        n              = 3'd4;
      end else if (item_last && phase_nxt == PH_2) begin
        b.item[1].data = b64_char(carry_nxt[5:0]);
        b.item[2].data = PAD_CHAR;
        n              = 3'd3;
      end
    end else begin
      if (!pad_r) begin
        cur_bad = (v == INVALID_VAL);
        case (phase_r)
          PH_0: begin
            carry_nxt = v;
            phase_nxt = PH_1;
          end
          PH_1: begin
            dec_b     = {carry_r[5:0], v[5:4]};
            b.item[0].data = dec_b ^ kb;
            b.item[0].bad  = cur_bad | prev_bad;
            kidx_nxt  = idx_adv;
            carry_nxt = v;
            phase_nxt = PH_2;
            n         = 3'd1;
          end
          default: begin
            if (item_byte == PAD_CHAR) begin
              pad_nxt = 1'b1;
              cur_bad = 1'b0;
            end else begin
              if (phase_r == PH_2) begin
                dec_b     = {carry_r[3:0], v[5:2]};
                carry_nxt = v;
                phase_nxt = PH_3;
              end else begin
                dec_b     = {carry_r[1:0], 6'b000000} | v;
                carry_nxt = 8'd0;
                phase_nxt = PH_0;
              end
              b.item[0].data = dec_b ^ kb;
              b.item[0].bad  = cur_bad | prev_bad;
              kidx_nxt       = idx_adv;
              n              = 3'd1;
            end
          end
        endcase
      end
      if (item_last && n == 3'd0) begin
        b.item[0].empty = 1'b1;
        b.item[0].bad   = cur_bad;
        n               = 3'd1;
      end
    end

    lidx = 2'(n - 3'd1);
    if (item_last) begin
      b.item[lidx].last = 1'b1;
      phase_nxt = PH_0;
      carry_nxt = 8'd0;
      kidx_nxt  = 3'd0;
      pad_nxt   = 1'b0;
    end
    b.cnt = n;
    batch = b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      phase_r <= PH_0;
      carry_r <= 8'd0;
      kidx_r  <= 3'd0;
      pad_r   <= 1'b0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      carry_r <= carry_nxt;
      kidx_r  <= kidx_nxt;
      pad_r   <= pad_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/xbc_emit.sv =====
// XOR/Base64 codec queue: holds one batch, sends one result a cycle if out_ready is set.
// Depends on xbc_pkg.
`default_nettype none
module xbc_emit (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            load,
  input  xbc_pkg::batch_t      batch,
  output logic                 free,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output xbc_pkg::res_t        out_res
);
  import xbc_pkg::*;

  res_t [MAX_RES-1:0] item_r, item_nxt;
  logic [2:0]         cnt_r, cnt_nxt;
  logic               pop;

  assign out_valid = (cnt_r != 3'd0);
  assign out_res   = item_r[0];
  assign pop       = out_valid && out_ready;
  // room for a new batch once the last queued result leaves this cycle
  assign free      = (cnt_r == 3'd0) || (cnt_r == 3'd1 && out_ready);

  always_comb begin
    item_nxt = item_r;
    cnt_nxt  = cnt_r;
    if (load) begin
      item_nxt = batch.item;
      cnt_nxt  = batch.cnt;
    end else if (pop) begin
      for (int i = 0; i < MAX_RES - 1; i++) begin
        item_nxt[i] = item_r[i+1];
      end
      cnt_nxt = cnt_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    if (!rst_n) begin
      cnt_r <= 3'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/xor_base64_codec_top.sv =====
// XOR/Base64 codec top level: register port, input register, core and result queue.
// Depends on xbc_pkg, xbc_core and xbc_emit.
//
//   channel  | direction | handshake                  | payload
//   in_      | slave     | in_tvalid / in_tready      | in_tdata = in_byte, in_tlast
//   out_     | master    | out_tvalid / out_tready    | out_tdata = out_byte, out_tlast,
//            |           |                            | out_tuser = {bad_char, out_empty}
//   cfg_     | APB slave | psel, penable, pready = 1  | mode @0x00, xor_key @0x08, key_length @0x10
//
// An accepted item waits in the input register until the queue is free; the core then turns it
// combinationally into a batch of up to four results, and the result queue sends one per cycle
// while out_tready is high. A new item enters every cycle while each item yields at most one
// result and out_ does not stall; encoding sends four characters for every three bytes, and a
// closing byte with padding yields up to four results, which hold the input until they drain.
// Reset is synchronous and active low; it empties both stages and clears the stream state.
// A stall on out_ holds the queue, which in turn holds the input register and in_tready.
`default_nettype none
module xor_base64_codec_top (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [7:0]                  in_tdata,   // [7:0] in_byte
  input  wire logic                        in_tlast,
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic [7:0]                       out_tdata,  // [7:0] out_byte
  output logic [1:0]                       out_tuser,  // [0] out_empty, [1] bad_char
  output logic                             out_tlast,
  input  wire logic                        cfg_psel,
  input  wire logic                        cfg_penable,
  input  wire logic                        cfg_pwrite,
  input  wire logic [xbc_pkg::ADDR_W-1:0]  cfg_paddr,
  input  wire logic [63:0]                 cfg_pwdata,
  output logic [63:0]                      cfg_prdata,
  output logic                             cfg_pready
);
  import xbc_pkg::*;

  logic        mode_r;
  logic [63:0] key_r;
  logic [3:0]  klen_r;
  logic [1:0]  reg_idx;
  logic        cfg_wr;

  logic        in_valid_r;
  logic [7:0]  in_byte_r;
  logic        in_last_r;
  logic        load;
  logic        free;
  batch_t      batch;
  res_t        out_res;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[ADDR_W-1:ADDR_W-2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_ENC;
      key_r  <= 64'd0;
      klen_r <= 4'd1;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_MODE:    mode_r <= cfg_pwdata[0];
        REG_XOR_KEY: key_r  <= cfg_pwdata;
        REG_KEY_LEN: klen_r <= cfg_pwdata[3:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MODE:    cfg_prdata = {63'd0, mode_r};
      REG_XOR_KEY: cfg_prdata = key_r;
      REG_KEY_LEN: cfg_prdata = {60'd0, klen_r};
      default:     cfg_prdata = 64'd0;
    endcase
  end

  // hand the registered item to the core once the queue can take its batch
  assign load      = in_valid_r && free;
  assign in_tready = !in_valid_r || load;

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  xbc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .clear     (cfg_wr && reg_idx == REG_MODE),
    .mode      (mode_r),
    .xor_key   (key_r),
    .key_len   (klen_r),
    .fire      (load),
    .item_byte (in_byte_r),
    .item_last (in_last_r),
    .batch     (batch)
  );

  xbc_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .batch     (batch),
    .free      (free),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = out_res.data;
  assign out_tuser = {out_res.bad, out_res.empty};
  assign out_tlast = out_res.last;

endmodule
`default_nettype wire

// ===== dv/xbc_codec_model_pkg.sv =====
// Scoreboard for the XOR/Base64 codec: keeps its own copy of the register set
// and stream state, predicts every result and checks the received ones.
// Depends on xbc_pkg for the register indexes, result type and pad character.
package xbc_codec_model_pkg;
  import xbc_pkg::*;

  localparam string B64_SET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  class codec_model;
    logic        mode;
    logic [63:0] key;
    logic [3:0]  key_len;
    logic [1:0]  phase;
    logic [7:0]  carry;
    logic [2:0]  key_pos;
    logic        pad_seen;
    res_t        symbol_q[$];
    int unsigned mismatches;

    function new();
      mode = MODE_ENC;
      key = '0;
      key_len = 4'd1;
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      phase = '0;
      carry = '0;
      key_pos = '0;
      pad_seen = 1'b0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [63:0] val);
      case (idx)
        REG_MODE: begin
          mode = val[0];
          restart();
        end
        REG_XOR_KEY: key = val;
        REG_KEY_LEN: key_len = val[3:0];
        default: ;
      endcase
    endfunction

    // Clamp the length into 1..KEY_BYTES and fall back to byte 0 when the
    // position has run past a shortened key.
    function logic [7:0] next_key();
      logic [3:0] span;
      logic [3:0] pos;
      span = key_len;
      if (span == 4'd0) span = 4'd1;
      if (span > KEY_LEN_MAX) span = KEY_LEN_MAX;
      pos = {1'b0, key_pos};
      if (pos >= span) pos = 4'd0;
      next_key = key[8*pos +: 8];
      key_pos = (pos + 4'd1 >= span) ? 3'd0 : 3'(pos + 4'd1);
    endfunction

    function logic [7:0] char_to_sextet(logic [7:0] ch);
      for (int i = 0; i < 64; i++)
        if (8'(B64_SET[i]) == ch) return 8'(i);
      return 8'hFF;
    endfunction

    function void add(logic [7:0] data, logic empty, logic bad);
      symbol_q.push_back(res_t'{data: data, empty: empty, last: 1'b0, bad: bad});
    endfunction

    function void add_char(logic [5:0] s);
      add(8'(B64_SET[s]), 1'b0, 1'b0);
    endfunction

    function void push_byte(logic [7:0] b, logic last);
      logic [7:0] x;
      logic [7:0] v;
      logic [7:0] joined;
      logic       cur_bad;
      logic       prev_bad;
      int         n0;
      n0 = symbol_q.size();
      cur_bad = 1'b0;
      if (mode == MODE_ENC) begin
        x = b ^ next_key();
        if (phase == 2'd0) begin
          add_char(x[7:2]);
          carry = {2'b00, x[1:0], 4'b0000};
          phase = 2'd1;
        end else if (phase == 2'd1) begin
          add_char({carry[5:4], x[7:4]});
          carry = {2'b00, x[3:0], 2'b00};
          phase = 2'd2;
        end else begin
          add_char({carry[5:2], x[7:6]});
          add_char(x[5:0]);
          carry = '0;
          phase = 2'd0;
        end
        if (last && phase != 2'd0) begin
          add_char(carry[5:0]);
          if (phase == 2'd1) add(PAD_CHAR, 1'b0, 1'b0);
          add(PAD_CHAR, 1'b0, 1'b0);
        end
      end else begin
        if (!pad_seen) begin
          v = char_to_sextet(b);
          prev_bad = (carry == 8'hFF);
          cur_bad = (v == 8'hFF);
          if (phase == 2'd0) begin
            carry = v;
            phase = 2'd1;
          end else if (phase == 2'd1) begin
            joined = {carry[5:0], v[5:4]};
            add(joined ^ next_key(), 1'b0, cur_bad | prev_bad);
            carry = v;
            phase = 2'd2;
          end else if (b == PAD_CHAR) begin
            pad_seen = 1'b1;
            cur_bad = 1'b0;
          end else if (phase == 2'd2) begin
            joined = {carry[3:0], v[5:2]};
            add(joined ^ next_key(), 1'b0, cur_bad | prev_bad);
            carry = v;
            phase = 2'd3;
          end else begin
            joined = {carry[1:0], 6'b000000} | v;
            add(joined ^ next_key(), 1'b0, cur_bad | prev_bad);
            carry = '0;
            phase = 2'd0;
          end
        end
        if (last && symbol_q.size() == n0) add(8'h00, 1'b1, cur_bad);
      end
      if (last) begin
        symbol_q[symbol_q.size()-1].last = 1'b1;
        restart();
      end
    endfunction

    function void check_symbol(res_t got);
      res_t want;
      if (symbol_q.size() == 0) begin
        $error("unexpected result: out_byte %02h, out_empty %0b, out_last %0b, bad_char %0b",
               got.data, got.empty, got.last, got.bad);
        mismatches++;
        return;
      end
      want = symbol_q.pop_front();
      if (got.data !== want.data) begin
        $error("out_byte: expected %02h, actual %02h", want.data, got.data);
        mismatches++;
      end
      if (got.empty !== want.empty) begin
        $error("out_empty: expected %0b, actual %0b", want.empty, got.empty);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $error("out_last: expected %0b, actual %0b", want.last, got.last);
        mismatches++;
      end
      if (got.bad !== want.bad) begin
        $error("bad_char: expected %0b, actual %0b", want.bad, got.bad);
        mismatches++;
      end
    endfunction

    function void close_out();
      if (symbol_q.size() != 0) begin
        $error("%0d expected results never arrived", symbol_q.size());
        mismatches++;
      end
    endfunction
  endclass

endpackage

// ===== dv/xor_base64_codec_top_tb.sv =====
// Testbench for xor_base64_codec_top: directed and random byte streams in both
// modes, random stalls on both channels, APB register writes between streams.
// Depends on xbc_pkg and xbc_codec_model_pkg.
module xor_base64_codec_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import xbc_pkg::*;
  import xbc_codec_model_pkg::*;

  localparam int DRAIN_CYCLES = 8;
  localparam int LIMIT_CYCLES = 200000;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [7:0]          in_tdata;   // [7:0] in_byte
  logic                in_tlast;
  logic                out_tvalid;
  logic                out_tready;
  logic [7:0]          out_tdata;  // [7:0] out_byte
  logic [1:0]          out_tuser;  // [0] out_empty, [1] bad_char
  logic                out_tlast;
  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [ADDR_W-1:0]   cfg_paddr;
  logic [63:0]         cfg_pwdata;
  logic [63:0]         cfg_prdata;
  logic                cfg_pready;

  codec_model codec = new();
  int          send_idle = 28;
  int          recv_idle = 47;
  int unsigned sent_items = 0;
  int unsigned cycles = 0;

  xor_base64_codec_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Check each result transfer, then pick the next ready level.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      codec.check_symbol(res_t'{data: out_tdata, empty: out_tuser[0],
                                last: out_tlast, bad: out_tuser[1]});
    out_tready <= ($urandom_range(99) >= recv_idle);
  end

  task automatic send_item(logic [7:0] b, logic last);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    codec.push_byte(b, last);
    sent_items++;
  endtask

  // Hold off until every expected result is in, then let the pipeline settle,
  // since ignored characters leave nothing to wait for.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (codec.symbol_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [63:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 3'b000};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    codec.write_reg(idx, val);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    // idle before the next setup phase
    @(posedge clk);
  endtask

  task automatic retune();
    logic [63:0] k;
    if ($urandom_range(1)) cfg_write(REG_MODE, 64'($urandom_range(1)));
    if ($urandom_range(1)) begin
      case ($urandom_range(2))
        0: k = '0;
        1: k = '1;
        default: k = {$urandom, $urandom};
      endcase
      cfg_write(REG_XOR_KEY, k);
    end
    if ($urandom_range(1))
      cfg_write(REG_KEY_LEN, 64'($urandom_range(3) == 0 ? $urandom_range(15)
                                                         : $urandom_range(1, 8)));
  endtask

  // Mostly alphabet text in decode mode, with noise, pads early and late,
  // and cut quartets. Some streams are left open to change the key length
  // mid-stream.
  task automatic run_stream();
    logic [7:0] txt[$];
    int         len;
    bit         open_end;
    len = $urandom_range(1, 10);
    if (codec.mode == MODE_ENC) begin
      repeat (len) txt.push_back(8'($urandom_range(255)));
    end else begin
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(9) == 0)
          txt.push_back($urandom_range(1) ? PAD_CHAR : 8'($urandom_range(255)));
        else
          txt.push_back(8'(B64_SET[$urandom_range(63)]));
      end
      if ($urandom_range(2) != 0 && len % 4 >= 2) begin
        txt.push_back(PAD_CHAR);
        if (len % 4 == 2 && $urandom_range(1)) txt.push_back(PAD_CHAR);
        repeat ($urandom_range(2)) txt.push_back(8'($urandom_range(255)));
      end
    end
    open_end = ($urandom_range(5) == 0);
    foreach (txt[i]) send_item(txt[i], !open_end && i == txt.size() - 1);
    wait_idle();
    if (open_end) cfg_write(REG_KEY_LEN, 64'($urandom_range(15)));
    else retune();
  endtask

  initial begin
    int unsigned goal;
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tlast    <= 1'b0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Encode with an all-ones key and an oversized length: one pad, two pads, none.
    cfg_write(REG_XOR_KEY, '1);
    cfg_write(REG_KEY_LEN, 64'd15);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b1);
    send_item(8'h80, 1'b1);
    send_item(8'h01, 1'b0);
    send_item(8'h02, 1'b0);
    send_item(8'h04, 1'b1);
    wait_idle();

    cfg_write(REG_MODE, 64'(MODE_DEC));
    cfg_write(REG_XOR_KEY, '0);
    cfg_write(REG_KEY_LEN, 64'd0);
    send_item("T", 1'b0);
    send_item("W", 1'b0);
    send_item("F", 1'b0);
    send_item("u", 1'b1);
    // pad ends the quartet; the rest is dropped until the closing transfer
    send_item("Q", 1'b0);
    send_item("Q", 1'b0);
    send_item(PAD_CHAR, 1'b0);
    send_item(PAD_CHAR, 1'b0);
    send_item("Z", 1'b1);
    // pad in first place and characters outside the alphabet
    send_item(PAD_CHAR, 1'b0);
    send_item("B", 1'b0);
    send_item("!", 1'b0);
    send_item(8'hFF, 1'b1);
    // quartet cut after one and after three characters
    send_item("z", 1'b1);
    send_item("+", 1'b0);
    send_item("/", 1'b0);
    send_item("9", 1'b1);
    // leave a stream open, then restart it by a mode write
    send_item("A", 1'b0);
    wait_idle();
    cfg_write(REG_MODE, 64'(MODE_DEC));

    for (int p = 0; p < 3; p++) begin
      send_idle = (p == 0) ? 28 : (p == 1) ? 47 : 0;
      recv_idle = (p == 0) ? 47 : (p == 1) ? 28 : 0;
      goal = sent_items + 45;
      while (sent_items < goal) run_stream();
    end

    wait_idle();
    codec.close_out();
    if (codec.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
